### rtl/tlf_pkg.sv
// ============================================================================
// tlf_pkg: shared definitions for the terminal line formatter
// Character codes, action and token codes, register indexes, the
// configuration record and the controller/datapath command and status types.
// ============================================================================
package tlf_pkg;

	// Default tab stop spacing, handed down from the top level.
	localparam int TAB_STOP_DEF = 8;

	// Column counter width and saturation limits.
	localparam int COL_W = 10;
	localparam logic [COL_W-1:0] COL_MAX = '1;
	localparam logic [7:0] PEND_MAX = 8'd255;
	localparam logic [7:0] GROUP_MIN = 8'd4;
	localparam logic [6:0] PAGE_MAX = 7'd96;

	// Character codes.
	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_FF = 8'd12;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	// Input actions.
	localparam logic [1:0] ACT_TEXT = 2'd0;
	localparam logic [1:0] ACT_EOF = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	// Token kinds.
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_NEWLINE = 2'd1;
	localparam logic [1:0] KIND_PAUSE = 2'd2;
	localparam logic [1:0] KIND_RUN = 2'd3;

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_MOTION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_LINES = 3'd5;

	localparam logic [7:0] RST_GROUP_LENGTH = 8'd22;
	localparam logic [7:0] RST_LINE_WIDTH = 8'd79;
	localparam logic [6:0] RST_PAGE_LENGTH = 7'd66;
	localparam logic RST_BACK_MOTION = 1'b1;
	localparam logic RST_RAW_MODE = 1'b0;
	localparam logic [15:0] RST_SKIP_LINES = 16'd0;

	typedef struct packed {
		logic [7:0]  group_length;
		logic [7:0]  line_width;
		logic [6:0]  page_length;
		logic        back_motion;
		logic        raw_mode;
		logic [15:0] skip_lines;
	} cfg_t;

	// Datapath operations issued by the controller, at most one per cycle.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CHAR,
		OP_EOL,
		OP_EOL_GATHER,
		OP_FLUSH,
		OP_START
	} op_t;

	typedef struct packed {
		op_t  op;
		logic ff;          // line end belongs to a form feed
		logic flush_last;  // a flushed run closes the item
	} cmd_t;

	typedef struct packed {
		logic slot_free;      // output register can take a token this cycle
		logic wrap;           // the offered byte would close the line
		logic line_nonempty;
		logic page_at_one;
		logic flush_first;    // a pending run must go out before a pause
	} status_t;

endpackage

### rtl/tlf_ifs.sv
// ============================================================================
// tlf_ifs: channel interfaces of the terminal line formatter
// Text input, token output and configuration write channels.
// ============================================================================
interface tlf_text_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] text_byte;
	modport source (output valid, action, text_byte, input ready);
	modport sink (input valid, action, text_byte, output ready);
endinterface

interface tlf_token_if;
	logic       valid;
	logic       ready;
	logic [1:0] token_kind;
	logic [7:0] out_byte;
	logic       blank_fill;
	logic [6:0] run_count;
	logic       last;
	modport source (output valid, token_kind, out_byte, blank_fill, run_count, last,
		input ready);
	modport sink (input valid, token_kind, out_byte, blank_fill, run_count, last,
		output ready);
endinterface

interface tlf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tlf_pkg::CFG_IDX_W-1:0]  index;
	logic [tlf_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/tlf_cfg_regs.sv
// ============================================================================
// tlf_cfg_regs: configuration register file
// Six registers written through the configuration channel; unknown indexes
// are accepted and ignored.
// ============================================================================
module tlf_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	tlf_cfg_if.sink        cfg,
	output tlf_pkg::cfg_t  regs
);

	tlf_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.group_length <= tlf_pkg::RST_GROUP_LENGTH;
			regs_q.line_width <= tlf_pkg::RST_LINE_WIDTH;
			regs_q.page_length <= tlf_pkg::RST_PAGE_LENGTH;
			regs_q.back_motion <= tlf_pkg::RST_BACK_MOTION;
			regs_q.raw_mode <= tlf_pkg::RST_RAW_MODE;
			regs_q.skip_lines <= tlf_pkg::RST_SKIP_LINES;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				tlf_pkg::REG_GROUP_LENGTH: regs_q.group_length <= cfg.data[7:0];
				tlf_pkg::REG_LINE_WIDTH: regs_q.line_width <= cfg.data[7:0];
				tlf_pkg::REG_PAGE_LENGTH: regs_q.page_length <= cfg.data[6:0];
				tlf_pkg::REG_BACK_MOTION: regs_q.back_motion <= cfg.data[0];
				tlf_pkg::REG_RAW_MODE: regs_q.raw_mode <= cfg.data[0];
				tlf_pkg::REG_SKIP_LINES: regs_q.skip_lines <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

### rtl/tlf_ctrl.sv
// ============================================================================
// tlf_ctrl: sequencing controller
// Owns the text handshake and, while the output slot is free, issues one
// datapath operation per cycle: a byte, line ends, start, the form feed walk.
// ============================================================================
module tlf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	tlf_text_if.sink         text,
	input  tlf_pkg::status_t status,
	output tlf_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EOL = 2'd1;
	localparam logic [1:0] S_FF = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign text.ready = (state_q == S_IDLE) && status.slot_free;
	assign accept = text.valid && text.ready;

	always_comb begin
		state_d = state_q;
		cmd.op = tlf_pkg::OP_NONE;
		cmd.ff = 1'b0;
		cmd.flush_last = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (text.action)
						tlf_pkg::ACT_TEXT: begin
							if (text.text_byte == tlf_pkg::CH_FF) begin
								cmd.op = tlf_pkg::OP_EOL;
								cmd.ff = 1'b1;
								state_d = S_FF;
							end else if (text.text_byte == tlf_pkg::CH_LF) begin
								cmd.op = tlf_pkg::OP_EOL;
							end else begin
								cmd.op = tlf_pkg::OP_CHAR;
								if (status.wrap) begin
									state_d = S_EOL;
								end
							end
						end
						tlf_pkg::ACT_EOF: begin
							if (status.line_nonempty) begin
								cmd.op = tlf_pkg::OP_EOL;
							end
						end
						tlf_pkg::ACT_START: cmd.op = tlf_pkg::OP_START;
						default: ;
					endcase
				end
			end
			S_EOL: begin
				if (status.slot_free) begin
					cmd.op = tlf_pkg::OP_EOL;
					state_d = S_IDLE;
				end
			end
			S_FF: begin
				if (status.slot_free) begin
					if (status.page_at_one) begin
						cmd.op = tlf_pkg::OP_FLUSH;
						cmd.flush_last = 1'b1;
						state_d = S_IDLE;
					end else if (status.flush_first) begin
						cmd.op = tlf_pkg::OP_FLUSH;
					end else begin
						cmd.op = tlf_pkg::OP_EOL_GATHER;
						cmd.ff = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/tlf_datapath.sv
// ============================================================================
// tlf_datapath: line state and token output register
// Holds column, backspace and overstrike state, the group, page and skip
// counters and the empty line run, and builds at most one token per operation.
// ============================================================================
module tlf_datapath #(
	parameter int TAB_STOP = tlf_pkg::TAB_STOP_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tlf_pkg::cfg_t           regs,
	input  tlf_pkg::cmd_t           cmd,
	input  logic [7:0]              text_byte,
	output tlf_pkg::status_t        status,
	tlf_token_if.source             token
);

	localparam int CW = tlf_pkg::COL_W;
	localparam int PH_W = $clog2(TAB_STOP);
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(TAB_STOP - 1);
	localparam logic [PH_W-1:0] PH_SAT = PH_W'(((2 ** CW) - 1) % TAB_STOP);
	localparam logic [CW:0] TAB_STEP = (CW + 1)'(TAB_STOP);

	logic [CW-1:0]   col_q;
	logic [PH_W-1:0] phase_q;
	logic            nonempty_q;
	logic [7:0]      pend_q;
	logic            over_q;
	logic [7:0]      group_q;
	logic [6:0]      page_q;
	logic [15:0]     skip_q;
	logic [6:0]      run_q;

	logic            tok_valid_q;
	logic [1:0]      tok_kind_q;
	logic [7:0]      tok_byte_q;
	logic            tok_fill_q;
	logic [6:0]      tok_run_q;
	logic            tok_last_q;

	logic            passing;
	logic            is_bs;
	logic            is_cr;
	logic            is_tab;
	logic            is_ctrl;
	logic            place;
	logic [CW:0]     tab_sum;
	logic [CW-1:0]   new_col;
	logic [PH_W-1:0] new_phase;
	logic            wrap;
	logic            tab_cut;
	logic [7:0]      glen;
	logic [6:0]      plen;
	logic [6:0]      page_next;
	logic            skipping;
	logic            pausing;
	logic            eol_last;

	logic            emit;
	logic [1:0]      e_kind;
	logic [7:0]      e_byte;
	logic            e_fill;
	logic [6:0]      e_run;
	logic            e_last;

	// Byte classification and where the byte leaves the column.
	assign passing = regs.raw_mode || regs.back_motion;
	assign is_bs = text_byte == tlf_pkg::CH_BS;
	assign is_cr = text_byte == tlf_pkg::CH_CR;
	assign is_tab = text_byte == tlf_pkg::CH_TAB;
	assign is_ctrl = (text_byte < tlf_pkg::CH_SPACE) && !is_tab;
	assign place = (is_bs || is_cr) ? passing :
		(is_ctrl ? regs.raw_mode : ((pend_q == 8'd0) && !over_q));
	assign tab_sum = {1'b0, col_q} + TAB_STEP - (CW + 1)'(phase_q);

	always_comb begin
		new_col = col_q;
		new_phase = phase_q;
		if (is_tab) begin
			if (tab_sum > {1'b0, tlf_pkg::COL_MAX}) begin
				new_col = tlf_pkg::COL_MAX;
				new_phase = PH_SAT;
			end else begin
				new_col = tab_sum[CW-1:0];
				new_phase = '0;
			end
		end else if (is_bs) begin
			if (col_q != '0) begin
				new_col = col_q - CW'(1);
				new_phase = (phase_q == '0) ? PH_LAST : phase_q - PH_W'(1);
			end
		end else if (col_q != tlf_pkg::COL_MAX) begin
			new_col = col_q + CW'(1);
			new_phase = (phase_q == PH_LAST) ? '0 : phase_q + PH_W'(1);
		end
	end

	assign wrap = place && (new_col >= {2'b00, regs.line_width});
	assign tab_cut = is_tab && wrap;

	// Line end decisions.
	assign glen = (regs.group_length < tlf_pkg::GROUP_MIN) ? tlf_pkg::GROUP_MIN :
		regs.group_length;
	assign plen = (regs.page_length > tlf_pkg::PAGE_MAX) ? tlf_pkg::PAGE_MAX :
		regs.page_length;
	assign page_next = (page_q >= plen) ? 7'd1 : page_q + 7'd1;
	assign skipping = skip_q != 16'd0;
	assign pausing = !skipping && (group_q >= glen);
	// Within a form feed, more tokens follow unless the page is complete.
	assign eol_last = !cmd.ff || (page_next == 7'd1);

	assign status.slot_free = !tok_valid_q || token.ready;
	assign status.wrap = wrap;
	assign status.line_nonempty = nonempty_q;
	assign status.page_at_one = page_q == 7'd1;
	assign status.flush_first = pausing && (run_q != 7'd0);

	always_comb begin
		emit = 1'b0;
		e_kind = tlf_pkg::KIND_CHAR;
		e_byte = 8'd0;
		e_fill = 1'b0;
		e_run = 7'd0;
		e_last = 1'b1;
		case (cmd.op)
			tlf_pkg::OP_CHAR: begin
				emit = place && !skipping && !tab_cut;
				e_byte = text_byte;
				e_last = !(wrap && !skipping);
			end
			tlf_pkg::OP_EOL, tlf_pkg::OP_EOL_GATHER: begin
				emit = !skipping && (pausing || (cmd.op == tlf_pkg::OP_EOL));
				e_kind = pausing ? tlf_pkg::KIND_PAUSE : tlf_pkg::KIND_NEWLINE;
				e_fill = pausing && !nonempty_q;
				e_last = eol_last;
			end
			tlf_pkg::OP_FLUSH: begin
				emit = run_q != 7'd0;
				e_kind = tlf_pkg::KIND_RUN;
				e_run = run_q;
				e_last = cmd.flush_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			phase_q <= '0;
			nonempty_q <= 1'b0;
			pend_q <= 8'd0;
			over_q <= 1'b0;
			group_q <= 8'd1;
			page_q <= 7'd1;
			skip_q <= 16'd0;
			run_q <= 7'd0;
		end else begin
			case (cmd.op)
				tlf_pkg::OP_CHAR: begin
					if (is_bs && !passing) begin
						if (pend_q != tlf_pkg::PEND_MAX) begin
							pend_q <= pend_q + 8'd1;
						end
					end else if (is_cr && !passing) begin
						over_q <= 1'b1;
					end else if (!is_ctrl && (pend_q != 8'd0)) begin
						pend_q <= pend_q - 8'd1;
					end
					if (place) begin
						col_q <= new_col;
						phase_q <= new_phase;
						if (!tab_cut) begin
							nonempty_q <= 1'b1;
						end
					end
				end
				tlf_pkg::OP_EOL, tlf_pkg::OP_EOL_GATHER: begin
					if (skipping) begin
						skip_q <= skip_q - 16'd1;
					end else if (pausing) begin
						group_q <= 8'd1;
					end else begin
						group_q <= group_q + 8'd1;
					end
					if (cmd.op == tlf_pkg::OP_EOL) begin
						run_q <= 7'd0;
					end else if (!skipping && !pausing) begin
						run_q <= run_q + 7'd1;
					end
					page_q <= page_next;
					col_q <= '0;
					phase_q <= '0;
					nonempty_q <= 1'b0;
					pend_q <= 8'd0;
					over_q <= 1'b0;
				end
				tlf_pkg::OP_FLUSH: run_q <= 7'd0;
				tlf_pkg::OP_START: begin
					skip_q <= regs.skip_lines;
					col_q <= '0;
					phase_q <= '0;
					nonempty_q <= 1'b0;
					pend_q <= 8'd0;
					over_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Output register: one token held until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (emit) begin
			tok_valid_q <= 1'b1;
		end else if (token.ready) begin
			tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tok_kind_q <= e_kind;
			tok_byte_q <= e_byte;
			tok_fill_q <= e_fill;
			tok_run_q <= e_run;
			tok_last_q <= e_last;
		end
	end

	assign token.valid = tok_valid_q;
	assign token.token_kind = tok_kind_q;
	assign token.out_byte = tok_byte_q;
	assign token.blank_fill = tok_fill_q;
	assign token.run_count = tok_run_q;
	assign token.last = tok_last_q;

endmodule

### rtl/terminal_line_formatter.sv
// ============================================================================
// terminal_line_formatter: text bytes to terminal tokens
// Top level joining the configuration registers, the sequencing controller
// and the line state datapath.
// ============================================================================
// Once a text beat is taken, its first token, if any, is in the output
// register on the next cycle. A byte that closes the line (by width or by a
// tab that reaches the wrap column) is followed by a separate line end
// operation. A form feed ends the current line, then each further line up to
// the end of the page, with an extra flush before each pause that must first
// send a pending run of empty lines, and a final flush that sends the last
// run, if there is one; page_length is counted as at least 1 and at most 96.
// The controller issues a single datapath operation per cycle into a
// one-token output register; a stalled token sink holds the controller,
// while the register still lets the next beat in on the cycle its token is
// taken. Start and end of file beats need at most one datapath operation,
// and configuration writes are never held off. There is no clearing pass
// after reset.
// ============================================================================
module terminal_line_formatter #(
	parameter int TAB_STOP = tlf_pkg::TAB_STOP_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tlf_text_if.sink     text,
	tlf_token_if.source  token,
	tlf_cfg_if.sink      cfg
);

	tlf_pkg::cfg_t    regs;
	tlf_pkg::cmd_t    cmd;
	tlf_pkg::status_t status;

	// Register file: to be written only while the block is idle; the block itself does not enforce this.
	tlf_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Controller: decides which operation the datapath performs each cycle.
	tlf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.status (status),
		.cmd    (cmd)
	);

	// Datapath: line state, counters and the token output register.
	tlf_datapath #(
		.TAB_STOP (TAB_STOP)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.cmd       (cmd),
		.text_byte (text.text_byte),
		.status    (status),
		.token     (token)
	);

endmodule

### rtl/tlf_checker.sv
// ============================================================================
// tlf_checker: port level checks for the terminal line formatter
// Token channel hold rules, nonzero run counts, and the ordering of text beats
// against the tokens that close each item.
// ============================================================================
module tlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       text_valid,
	input logic       text_ready,
	input logic       token_valid,
	input logic       token_ready,
	input logic [1:0] token_kind,
	input logic [7:0] out_byte,
	input logic       blank_fill,
	input logic [6:0] run_count,
	input logic       last
);

	logic text_acc;
	logic tok_acc;
	logic open_q;

	assign text_acc = text_valid && text_ready;
	assign tok_acc = token_valid && token_ready;

	// Set while a delivered token promised more tokens for the same item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (tok_acc) begin
			open_q <= !last;
		end
	end

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid)
		else $error("token beat withdrawn before it was taken");

	a_tok_stable: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=>
		$stable({token_kind, out_byte, blank_fill, run_count, last}))
		else $error("stalled token changed");

	a_text_slot: assert property (@(posedge clk) disable iff (!arst_n)
		text_acc |-> !token_valid || token_ready)
		else $error("text beat taken while a token was stalled");

	a_text_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_acc |-> !open_q || (tok_acc && last))
		else $error("text beat taken before the previous item was closed");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind == tlf_pkg::KIND_RUN) |-> run_count != 7'd0)
		else $error("empty line run token with zero count");

endmodule

bind terminal_line_formatter tlf_checker u_tlf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.text_valid  (text.valid),
	.text_ready  (text.ready),
	.token_valid (token.valid),
	.token_ready (token.ready),
	.token_kind  (token.token_kind),
	.out_byte    (token.out_byte),
	.blank_fill  (token.blank_fill),
	.run_count   (token.run_count),
	.last        (token.last)
);
